[hw/rtl/scc_pkg.sv]
// Package for the SAT clause checker: codes, widths, types and literal helpers.
package scc_pkg;

    localparam int DEF_MAX_CLAUSES = 256;
    localparam int DEF_MAX_VARS    = 64;

    localparam int ACT_W    = 2;
    localparam int LIT_W    = 8;
    localparam int CLAUSE_W = 3 * LIT_W;
    localparam int BITS_W   = 64;
    localparam int CNT_W    = 7;
    localparam int HELD_W   = 9;

    // Largest magnitude a stored literal can have for a check to treat it as a variable.
    localparam logic [LIT_W-1:0] CHECK_VAR_LIMIT = 8'd64;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CHECK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic sat;
        logic full;
    } eval_t;

    typedef struct packed {
        logic assigned;
        logic truth;
    } lit_eval_t;

    function automatic logic [LIT_W-1:0] lit_mag(input logic [LIT_W-1:0] lit);
        logic [LIT_W-1:0] mag;
        begin
            mag = lit[LIT_W-1] ? (~lit + 1'b1) : lit;
            return mag;
        end
    endfunction

    function automatic lit_eval_t lit_eval(
        input logic [LIT_W-1:0]  lit,
        input logic [BITS_W-1:0] bits,
        input logic [CNT_W-1:0]  count
    );
        lit_eval_t        res;
        logic [LIT_W-1:0] mag;
        logic [LIT_W-1:0] idx;
        logic             val;
        begin
            mag = lit_mag(lit);
            idx = mag - 1'b1;
            val = bits[idx[5:0]];
            res.assigned = (mag != '0) && (mag <= CHECK_VAR_LIMIT)
                           && (mag <= {1'b0, count});
            res.truth    = lit[LIT_W-1] ? !val : val;
            return res;
        end
    endfunction

endpackage

[hw/rtl/scc_if.sv]
// Handshake channel interfaces for the request and response beats.
interface scc_req_if;
    logic                              valid;
    logic                              ready;
    logic [scc_pkg::ACT_W-1:0]         action;
    logic signed [scc_pkg::LIT_W-1:0]  lit_first;
    logic signed [scc_pkg::LIT_W-1:0]  lit_second;
    logic signed [scc_pkg::LIT_W-1:0]  lit_third;
    logic [scc_pkg::BITS_W-1:0]        assign_bits;
    logic [scc_pkg::CNT_W-1:0]         assigned_count;

    modport source (
        output valid, action, lit_first, lit_second, lit_third, assign_bits, assigned_count,
        input  ready
    );
    modport sink (
        input  valid, action, lit_first, lit_second, lit_third, assign_bits, assigned_count,
        output ready
    );
endinterface

interface scc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic                       promising;
    logic                       is_solution;
    logic [scc_pkg::HELD_W-1:0] clauses_held;

    modport source (
        output valid, accepted, promising, is_solution, clauses_held,
        input  ready
    );
    modport sink (
        input  valid, accepted, promising, is_solution, clauses_held,
        output ready
    );
endinterface

[hw/rtl/scc_clause_mem.sv]
// Clause table: one write port and one registered read port.
module scc_clause_mem #(
    parameter int MAX_CLAUSES = scc_pkg::DEF_MAX_CLAUSES,
    parameter int AW          = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [scc_pkg::CLAUSE_W-1:0]  wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [scc_pkg::CLAUSE_W-1:0]  rdata
);

    logic [scc_pkg::CLAUSE_W-1:0] mem [MAX_CLAUSES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/scc_clause_eval.sv]
// Evaluates one stored clause against a partial assignment.
module scc_clause_eval (
    input  logic [scc_pkg::CLAUSE_W-1:0] word,
    input  logic [scc_pkg::BITS_W-1:0]   bits,
    input  logic [scc_pkg::CNT_W-1:0]    count,
    output scc_pkg::eval_t               result
);

    scc_pkg::lit_eval_t lits [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lits[k] = scc_pkg::lit_eval(word[k*scc_pkg::LIT_W +: scc_pkg::LIT_W], bits, count);
        end
    end

    // A literal that is out of range or not yet assigned leaves the clause open.
    always_comb
    begin
        result.sat  = (lits[0].assigned && lits[0].truth)
                   || (lits[1].assigned && lits[1].truth)
                   || (lits[2].assigned && lits[2].truth);
        result.full = lits[0].assigned && lits[1].assigned && lits[2].assigned;
    end

endmodule

[hw/rtl/sat_clause_checker_unit.sv]
// Top level of the SAT clause checker: sequencer, clause counters and response register.
//
// The block takes request beats on req_ch and returns exactly one response beat on
// rsp_ch for each. A load beat appends a clause to the table, a clear beat empties
// it, and a check beat walks every stored clause against the partial assignment.
// Loads and clears answer in the cycle after the request is taken. A check reads one
// clause per cycle from the clause table's single read port, so its answer waits
// until every stored clause has been read and evaluated; the block takes no new
// request while a check walks the table.
// The response sits in an output register; a new request is taken while it waits
// only when the block is idle and the register is free or being emptied in the
// same cycle. A stalled receiver therefore holds off further requests.
// Reset clears the clause count, the highest variable and the sequencer at once;
// the table contents need no clearing since only counted entries are ever read.
// Rejected loads (zero or out-of-range literal, full table) answer with accepted
// low and leave the state unchanged.
module sat_clause_checker_unit #(
    parameter int MAX_CLAUSES = scc_pkg::DEF_MAX_CLAUSES,
    parameter int MAX_VARS    = scc_pkg::DEF_MAX_VARS
) (
    input  logic     clk,
    input  logic     rst_n,
    scc_req_if.sink  req_ch,
    scc_rsp_if.source rsp_ch
);

    localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int TW = $clog2(MAX_CLAUSES + 1);
    localparam logic [TW-1:0] TOTAL_MAX = TW'(MAX_CLAUSES);
    localparam logic [scc_pkg::LIT_W-1:0] VAR_MAX = scc_pkg::LIT_W'(MAX_VARS);

    scc_pkg::state_t state_reg, state_next;

    logic [TW-1:0]                total_reg, total_next;
    logic [scc_pkg::CNT_W-1:0]    highest_reg, highest_next;
    logic [TW-1:0]                rd_idx_reg, rd_idx_next;
    logic                         pend_reg, pend_next;
    logic [scc_pkg::BITS_W-1:0]   bits_reg, bits_next;
    logic [scc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         all_sat_reg, all_sat_next;
    logic                         prom_reg, prom_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_acc_reg, out_acc_next;
    logic                         out_prom_reg, out_prom_next;
    logic                         out_sol_reg, out_sol_next;

    logic                         take;
    logic                         issue;
    logic                         finish;
    logic                         load_ok;
    logic                         mem_we;
    logic [scc_pkg::CLAUSE_W-1:0] mem_rdata;
    scc_pkg::eval_t               eval;

    logic [scc_pkg::LIT_W-1:0]    mag0, mag1, mag2;
    logic [scc_pkg::LIT_W-1:0]    hi_a, hi_b, hi_c;

    assign take = req_ch.valid && req_ch.ready;

    // Load checks and the running highest variable.
    always_comb
    begin
        mag0 = scc_pkg::lit_mag(req_ch.lit_first);
        mag1 = scc_pkg::lit_mag(req_ch.lit_second);
        mag2 = scc_pkg::lit_mag(req_ch.lit_third);
        load_ok = (total_reg < TOTAL_MAX)
               && (mag0 != '0) && (mag0 <= VAR_MAX)
               && (mag1 != '0) && (mag1 <= VAR_MAX)
               && (mag2 != '0) && (mag2 <= VAR_MAX);
        hi_a = {1'b0, highest_reg};
        hi_b = (mag0 > hi_a) ? mag0 : hi_a;
        hi_c = (mag1 > hi_b) ? mag1 : hi_b;
        hi_c = (mag2 > hi_c) ? mag2 : hi_c;
    end

    assign mem_we = take && (req_ch.action == scc_pkg::ACT_LOAD) && load_ok;

    scc_clause_mem #(
        .MAX_CLAUSES (MAX_CLAUSES),
        .AW          (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (total_reg[AW-1:0]),
        .wdata ({req_ch.lit_third, req_ch.lit_second, req_ch.lit_first}),
        .re    (issue),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    scc_clause_eval u_eval (
        .word   (mem_rdata),
        .bits   (bits_reg),
        .count  (count_reg),
        .result (eval)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (take && (req_ch.action == scc_pkg::ACT_CHECK))
                begin
                    state_next = scc_pkg::ST_WALK;
                end
            end
            scc_pkg::ST_WALK:
            begin
                if (finish)
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req_ch.ready = 1'b0;
        issue        = 1'b0;
        finish       = 1'b0;
        case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                req_ch.ready = !out_valid_reg || rsp_ch.ready;
            end
            scc_pkg::ST_WALK:
            begin
                issue  = rd_idx_reg < total_reg;
                finish = (rd_idx_reg >= total_reg) && !pend_reg;
            end
            default:
            begin
                req_ch.ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        total_next     = total_reg;
        highest_next   = highest_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = issue;
        bits_next      = bits_reg;
        count_next     = count_reg;
        all_sat_next   = all_sat_reg;
        prom_next      = prom_reg;
        out_valid_next = out_valid_reg && !rsp_ch.ready;
        out_acc_next   = out_acc_reg;
        out_prom_next  = out_prom_reg;
        out_sol_next   = out_sol_reg;

        if (take)
        begin
            case (req_ch.action)
                scc_pkg::ACT_LOAD:
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = load_ok;
                    out_prom_next  = 1'b0;
                    out_sol_next   = 1'b0;
                    if (load_ok)
                    begin
                        total_next   = total_reg + 1'b1;
                        highest_next = hi_c[scc_pkg::CNT_W-1:0];
                    end
                end
                scc_pkg::ACT_CHECK:
                begin
                    bits_next    = req_ch.assign_bits;
                    count_next   = req_ch.assigned_count;
                    rd_idx_next  = '0;
                    all_sat_next = 1'b1;
                    prom_next    = 1'b1;
                end
                scc_pkg::ACT_CLEAR:
                begin
                    total_next     = '0;
                    highest_next   = '0;
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b1;
                    out_prom_next  = 1'b0;
                    out_sol_next   = 1'b0;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = 1'b0;
                    out_prom_next  = 1'b0;
                    out_sol_next   = 1'b0;
                end
            endcase
        end

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end

        // Read data for the clause issued last cycle is evaluated now.
        if (pend_reg && !eval.sat)
        begin
            all_sat_next = 1'b0;
            if (eval.full)
            begin
                prom_next = 1'b0;
            end
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
            out_acc_next   = 1'b0;
            out_prom_next  = prom_reg;
            out_sol_next   = all_sat_reg && (count_reg == highest_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scc_pkg::ST_IDLE;
            total_reg     <= '0;
            highest_reg   <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            highest_reg   <= highest_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        count_reg    <= count_next;
        all_sat_reg  <= all_sat_next;
        prom_reg     <= prom_next;
        out_acc_reg  <= out_acc_next;
        out_prom_reg <= out_prom_next;
        out_sol_reg  <= out_sol_next;
    end

    assign rsp_ch.valid        = out_valid_reg;
    assign rsp_ch.accepted     = out_acc_reg;
    assign rsp_ch.promising    = out_prom_reg;
    assign rsp_ch.is_solution  = out_sol_reg;
    assign rsp_ch.clauses_held = scc_pkg::HELD_W'(total_reg);

endmodule
